### hdl/phe_pkg.sv
// Shared types, constants and saturation helper for the Horner evaluator.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package phe_pkg;

    localparam int MAX_DEGREE = 6;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_CELLS  = MAX_DEGREE + 1;

    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DEG_W      = 3;
    // wide enough for a coefficient times its largest derivative scale
    localparam int SCALE_W    = VAL_W + $clog2(MAX_DEGREE + 2);

    localparam int NUM_COEF_REGS = 7;
    localparam int NUM_CFG_REGS  = NUM_COEF_REGS + 1;
    localparam int CFG_IDX_W     = $clog2(NUM_CFG_REGS);

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = CFG_IDX_W'(1);

    localparam logic [0:0] ACT_VALUE = 1'b0;
    localparam logic [0:0] ACT_DERIV = 1'b1;

    localparam logic signed [PROD_W-1:0] VAL_MAX =
        {{(PROD_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] VAL_MIN = ~VAL_MAX;

    typedef struct packed {
        logic signed [VAL_W-1:0] point;
        logic                    action;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    overflow;
    } t_result;

    // data handed from one cell to the next
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] point;
        logic                    action;
        logic signed [VAL_W-1:0] acc;
        logic                    ovf;
    } t_stage;

    // per-cell coefficients, already masked by degree
    typedef struct packed {
        logic signed [VAL_W-1:0] val_coef;
        logic signed [VAL_W-1:0] drv_coef;
        logic                    drv_ovf;
    } t_coef;

    typedef struct packed {
        logic                    ovf;
        logic signed [VAL_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_val(input logic signed [PROD_W-1:0] v);
        t_sat s;
        if (v > VAL_MAX) begin
            s.ovf = 1'b1;
            s.val = VAL_MAX[VAL_W-1:0];
        end else if (v < VAL_MIN) begin
            s.ovf = 1'b1;
            s.val = VAL_MIN[VAL_W-1:0];
        end else begin
            s.ovf = 1'b0;
            s.val = v[VAL_W-1:0];
        end
        return s;
    endfunction

endpackage

### hdl/phe_coef_bank.sv
// Configuration registers (degree and coefficients) and per-cell coefficient prep.
// Depends on phe_pkg.
`timescale 1ns / 1ps

module phe_coef_bank
    import phe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data,
    output t_coef                o_coef [NUM_CELLS]
);

    logic [DEG_W-1:0]        r_degree;
    logic signed [VAL_W-1:0] r_coef [NUM_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            for (int i = 0; i < NUM_CELLS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DEGREE) begin
                r_degree <= i_cfg_data[DEG_W-1:0];
            end
            // coefficients above the top cell have no storage: drop the write
            for (int i = 0; i < NUM_CELLS; i++) begin
                if (i < NUM_COEF_REGS && int'(i_cfg_idx) == int'(REG_COEF_0) + i) begin
                    r_coef[i] <= i_cfg_data;
                end
            end
        end
    end

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_prep
        logic in_val;
        logic in_drv;

        // k <= min(degree, MAX) reduces to k <= degree since k never exceeds MAX
        assign in_val = int'(r_degree) >= k;
        assign in_drv = (int'(r_degree) > k) && (k < MAX_DEGREE);

        assign o_coef[k].val_coef = in_val ? r_coef[k] : '0;

        if (k < MAX_DEGREE) begin : g_scale
            localparam int MULT = k + 1;
            logic signed [SCALE_W-1:0] scaled;
            t_sat                      s;

            assign scaled = SCALE_W'(r_coef[k+1]) * SCALE_W'(MULT);
            assign s      = sat_val(PROD_W'(scaled));

            assign o_coef[k].drv_coef = in_drv ? s.val : '0;
            assign o_coef[k].drv_ovf  = in_drv & s.ovf;
        end else begin : g_top
            // the top cell's derivative term is always zero
            assign o_coef[k].drv_coef = '0;
            assign o_coef[k].drv_ovf  = in_drv;
        end
    end

endmodule

### hdl/phe_cell.sv
// One Horner step: multiply the running value by x, then shift, add and saturate.
// Two register stages per cell. Depends on phe_pkg.
`timescale 1ns / 1ps

module phe_cell
    import phe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    input  t_coef  i_coef,
    output t_stage o_stage
);

    // multiply stage
    logic                     r_a_valid, n_a_valid;
    logic signed [VAL_W-1:0]  r_a_point, n_a_point;
    logic                     r_a_action, n_a_action;
    logic signed [PROD_W-1:0] r_a_prod, n_a_prod;
    logic signed [VAL_W-1:0]  r_a_coef, n_a_coef;
    logic                     r_a_ovf, n_a_ovf;

    // add stage
    t_stage                   r_b, n_b;

    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] sum;
    t_sat                     s;

    always_comb begin
        n_a_valid  = i_stage.valid;
        n_a_point  = i_stage.point;
        n_a_action = i_stage.action;
        n_a_prod   = PROD_W'(i_stage.point) * PROD_W'(i_stage.acc);
        if (i_stage.action == ACT_DERIV) begin
            n_a_coef = i_coef.drv_coef;
            n_a_ovf  = i_stage.ovf | i_coef.drv_ovf;
        end else begin
            n_a_coef = i_coef.val_coef;
            n_a_ovf  = i_stage.ovf;
        end
    end

    always_comb begin
        // arithmetic shift floors toward minus infinity
        shifted     = r_a_prod >>> FRAC_BITS;
        sum         = shifted + PROD_W'(r_a_coef);
        s           = sat_val(sum);
        n_b.valid   = r_a_valid;
        n_b.point   = r_a_point;
        n_b.action  = r_a_action;
        n_b.acc     = s.val;
        n_b.ovf     = r_a_ovf | s.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b       <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b       <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_point  <= n_a_point;
        r_a_action <= n_a_action;
        r_a_prod   <= n_a_prod;
        r_a_coef   <= n_a_coef;
        r_a_ovf    <= n_a_ovf;
    end

    assign o_stage = r_b;

    a_valid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |=> r_b.valid)
        else $error("item lost between multiply and add stage");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |=> !r_b.valid)
        else $error("add stage valid without a multiply stage item");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_ovf) |=> r_b.ovf)
        else $error("overflow flag dropped inside cell");

    a_point_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |=> (r_b.point == $past(r_a_point) && r_b.action == $past(r_a_action)))
        else $error("point or action changed inside cell");

endmodule

### hdl/polynomial_horner_evaluator.sv
// Top level of the Horner polynomial evaluator: coefficient bank and cell chain.
// Depends on phe_pkg, phe_coef_bank and phe_cell.
`timescale 1ns / 1ps

// Pipelined Horner evaluator. One item (point, action) is accepted in every cycle;
// busy is never raised. The result appears on o_result with o_strobe high for one
// cycle, after the item has passed through the chain of cells: the chain has one cell
// per coefficient, each with a multiply register and an add/saturate register.
// Results come out in order and cannot be held off, so the receiver must take each
// one in its strobe cycle. Write configuration only with no item in flight.
module polynomial_horner_evaluator
    import phe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    t_coef  coef  [NUM_CELLS];
    t_stage chain [NUM_CELLS + 1];

    phe_coef_bank u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef)
    );

    assign busy = 1'b0;

    // head of chain starts from a zero accumulator
    assign chain[0].valid  = start & ~busy;
    assign chain[0].point  = i_item.point;
    assign chain[0].action = i_item.action;
    assign chain[0].acc    = '0;
    assign chain[0].ovf    = 1'b0;

    // first cell handles the top coefficient, last cell the constant term
    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        phe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[j]),
            .i_coef  (coef[MAX_DEGREE - j]),
            .o_stage (chain[j+1])
        );
    end

    assign o_strobe          = chain[NUM_CELLS].valid;
    assign o_result.value    = chain[NUM_CELLS].acc;
    assign o_result.overflow = chain[NUM_CELLS].ovf;

endmodule

### verif/polynomial_horner_evaluator_tb.sv
// Self-checking testbench for polynomial_horner_evaluator: directed and random items,
// checked against an in-bench Horner predictor. Depends on phe_pkg and the block's RTL.
`timescale 1ns / 1ps

module polynomial_horner_evaluator_tb;
    import phe_pkg::*;

    // pipeline depth plus a margin, used after each drain
    localparam int SETTLE_CYCLES = 2 * NUM_CELLS + 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [VAL_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [VAL_W-1:0] Q_NEG_ONE = 32'hffff_0000;
    localparam logic [VAL_W-1:0] Q_MAX     = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [VAL_W-1:0] Q_LSB_NEG = 32'hffff_ffff;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483647 - 64'sd1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_strobe;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0]     i_cfg_data;

    // shadow copy of the configuration registers
    logic [DEG_W-1:0]        deg_shadow;
    logic signed [VAL_W-1:0] coef_shadow [0:MAX_DEGREE];

    t_result pending_results [$];
    t_result want;
    int      error_count;
    int      calm_left;
    int      waited;

    polynomial_horner_evaluator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_q(input longint v, inout bit ovf);
        if (v > SAT_HI) begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // Horner evaluation of the value or the first derivative at the item's point
    function automatic t_result horner_predict(input t_item it);
        t_result res;
        longint  x;
        longint  acc;
        longint  term;
        bit      ovf;
        int      top;
        int      k;
        ovf = 1'b0;
        acc = 0;
        x   = longint'($signed(it.point));
        top = (int'(deg_shadow) > MAX_DEGREE) ? MAX_DEGREE : int'(deg_shadow);
        if (it.action == ACT_DERIV) begin
            for (k = top - 1; k >= 0; k--) begin
                term = clamp_q(longint'(coef_shadow[k + 1]) * longint'(k + 1), ovf);
                acc  = clamp_q(((x * acc) >>> FRAC_BITS) + term, ovf);
            end
        end else begin
            for (k = top; k >= 0; k--) begin
                acc = clamp_q(((x * acc) >>> FRAC_BITS) + longint'(coef_shadow[k]), ovf);
            end
        end
        res.value    = acc[VAL_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    // mostly small magnitudes so that the chain does not saturate on every item
    function automatic logic [VAL_W-1:0] rand_q();
        logic [VAL_W-1:0] r;
        logic [VAL_W-1:0] res;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: res = {{13{r[31]}}, r[18:0]};
            4, 5:       res = {{15{r[31]}}, r[16:0]};
            6:          res = {{9{r[31]}}, r[22:0]};
            7: begin
                case ($urandom_range(0, 3))
                    0:       res = Q_MAX;
                    1:       res = Q_MIN;
                    2:       res = '0;
                    default: res = Q_LSB_NEG;
                endcase
            end
            default:    res = r;
        endcase
        return res;
    endfunction

    task automatic flag_error(input string what);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result with none expected: value=%h overflow=%b",
                                     o_result.value, o_result.overflow));
            end else begin
                want = pending_results.pop_front();
                if (o_result.value !== want.value)
                    flag_error($sformatf("value expected %h got %h",
                                         want.value, o_result.value));
                if (o_result.overflow !== want.overflow)
                    flag_error($sformatf("overflow expected %b got %b (value %h)",
                                         want.overflow, o_result.overflow, want.value));
            end
        end
    end

    task automatic send_item(input logic [VAL_W-1:0] pt, input logic act);
        @(negedge i_clk);
        start         = 1'b1;
        i_item.point  = pt;
        i_item.action = act;
        @(posedge i_clk);
        while (busy === 1'b1) @(posedge i_clk);
        pending_results.insert(pending_results.size(), horner_predict(i_item));
    endtask

    // idle the sender at random, with occasional back-to-back stretches
    task automatic pace(input int idle_pct);
        int gap;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 40);
        end else if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge i_clk);
                start = 1'b0;
            end
        end
    endtask

    // hold off until every expected item is back and the chain is empty
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx == REG_DEGREE)
            deg_shadow = data[DEG_W-1:0];
        else
            coef_shadow[idx - REG_COEF_0] = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic fill_coefs(input logic [VAL_W-1:0] data);
        int k;
        for (k = 0; k <= MAX_DEGREE; k++)
            write_reg(REG_COEF_0 + CFG_IDX_W'(k), data);
    endtask

    task automatic randomize_config();
        logic [VAL_W-1:0] r;
        int k;
        r = $urandom;
        write_reg(REG_DEGREE, {r[VAL_W-1:DEG_W], DEG_W'($urandom_range(0, 7))});
        for (k = 0; k <= MAX_DEGREE; k++)
            write_reg(REG_COEF_0 + CFG_IDX_W'(k), rand_q());
    endtask

    // reset configuration: degree 0, all coefficients zero
    task automatic test_reset_state();
        send_item(Q_MAX, ACT_VALUE);
        send_item(Q_MIN, ACT_DERIV);
        send_item(Q_ONE, ACT_VALUE);
        wait_idle();
    endtask

    // floor rounding of negative products and a plain linear case
    task automatic test_rounding();
        write_reg(REG_DEGREE, 32'd1);
        write_reg(REG_COEF_0, Q_ONE);
        write_reg(REG_COEF_0 + CFG_IDX_W'(1), 32'd3);
        send_item(Q_LSB_NEG, ACT_VALUE);
        send_item(32'd1, ACT_VALUE);
        send_item(Q_NEG_ONE, ACT_VALUE);
        wait_idle();
        write_reg(REG_COEF_0 + CFG_IDX_W'(1), Q_NEG_ONE);
        send_item(32'h0002_8000, ACT_VALUE);
        send_item(Q_LSB_NEG, ACT_DERIV);
        wait_idle();
    endtask

    // saturation in the multiply-add and in the derivative scaling
    task automatic test_saturation();
        write_reg(REG_DEGREE, MAX_DEGREE);
        fill_coefs(Q_MAX);
        send_item(Q_MAX, ACT_VALUE);
        send_item(Q_MAX, ACT_DERIV);
        send_item(32'd0, ACT_VALUE);
        send_item(32'd0, ACT_DERIV);
        wait_idle();
        fill_coefs(Q_MIN);
        send_item(Q_MAX, ACT_VALUE);
        send_item(Q_MIN, ACT_VALUE);
        send_item(Q_MIN, ACT_DERIV);
        wait_idle();
    endtask

    // degree above the chain length clamps; derivative of a constant is zero
    task automatic test_degree_limits();
        fill_coefs(Q_ONE);
        write_reg(REG_DEGREE, 32'd7);
        send_item(Q_ONE, ACT_VALUE);
        send_item(Q_NEG_ONE, ACT_VALUE);
        send_item(Q_ONE, ACT_DERIV);
        wait_idle();
        write_reg(REG_DEGREE, 32'd0);
        send_item(Q_MAX, ACT_VALUE);
        send_item(Q_MAX, ACT_DERIV);
        wait_idle();
    endtask

    task automatic test_random_phase(input int idle_pct, input int n_items);
        int s;
        int i;
        for (s = 0; s < 4; s++) begin
            wait_idle();
            randomize_config();
            for (i = 0; i < n_items / 4; i++) begin
                send_item(rand_q(), 1'($urandom_range(0, 1)));
                pace(idle_pct);
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        deg_shadow  = '0;
        for (int k = 0; k <= MAX_DEGREE; k++)
            coef_shadow[k] = '0;
        error_count = 0;
        calm_left   = 0;
        waited      = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_rounding();
        test_saturation();
        test_degree_limits();
        test_random_phase(0, 256);
        test_random_phase(72, 256);
        test_random_phase(25, 256);
        test_random_phase(0, 256);

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d expected results never came",
                                 pending_results.size()));

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
